FILE: rtl/pat_pkg.sv
`timescale 1ns / 1ps

package pat_pkg;

  localparam int unsigned TableDepth = 16;

  localparam logic [31:0] LimitReset = 32'd60;

  localparam logic [2:0] CmdTick   = 3'd0;
  localparam logic [2:0] CmdTouch  = 3'd1;
  localparam logic [2:0] CmdAdd    = 3'd2;
  localparam logic [2:0] CmdRemove = 3'd3;
  localparam logic [2:0] CmdQuery  = 3'd4;
  localparam logic [2:0] CmdSweep  = 3'd5;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFull     = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;

  localparam logic [4:0] FreedMax = 5'd31;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] ip_address;
    logic [15:0] port_number;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       present;
    logic [4:0] freed_count;
  } out_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] last_seen;
  } entry_t;

endpackage

FILE: rtl/pat_mem.sv
`timescale 1ns / 1ps

module pat_mem #(
  parameter int unsigned DEPTH = pat_pkg::TableDepth,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  pat_pkg::entry_t  wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output pat_pkg::entry_t  rdata_o
);

  pat_pkg::entry_t mem [DEPTH];
  pat_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pat_ctrl.sv
`timescale 1ns / 1ps

module pat_ctrl #(
  parameter int unsigned TABLE_DEPTH = pat_pkg::TableDepth,
  parameter int unsigned IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         inactive_limit_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pat_pkg::in_t        in_data_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output pat_pkg::out_t       res_data_o,
  output logic                mem_re_o,
  output logic [IDX_W-1:0]    mem_raddr_o,
  input  pat_pkg::entry_t     mem_rdata_i,
  output logic                mem_we_o,
  output logic [IDX_W-1:0]    mem_waddr_o,
  output pat_pkg::entry_t     mem_wdata_o
);

  localparam int unsigned CntW = IDX_W + 1;
  localparam logic [CntW-1:0] Depth = CntW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StApply,
    StFinish
  } state_e;

  state_e               state_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [31:0]          now_q;
  logic [2:0]           cmd_q;
  logic [31:0]          ip_q;
  logic [15:0]          port_q;
  logic [CntW-1:0]      rd_cnt_q;
  logic                 cmp_vld_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic                 hit_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic                 free_found_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic [4:0]           freed_q;
  pat_pkg::out_t        res_q;
  pat_pkg::out_t        res_d;

  logic                 is_store;
  logic                 do_ins;
  logic                 do_ref;
  logic                 cmp_valid;
  logic                 cmp_match;
  logic                 cmp_old;
  logic [31:0]          age;

  assign is_store  = (cmd_q == pat_pkg::CmdTouch) || (cmd_q == pat_pkg::CmdAdd);
  assign do_ins    = is_store && !hit_q && free_found_q;
  assign do_ref    = (cmd_q == pat_pkg::CmdTouch) && hit_q;

  assign cmp_valid = valid_q[cmp_idx_q];
  assign cmp_match = cmp_valid && (mem_rdata_i.ip == ip_q) && (mem_rdata_i.port == port_q);
  assign age       = now_q - mem_rdata_i.last_seen;
  assign cmp_old   = cmp_valid && (age > inactive_limit_i);

  assign in_ready_o  = (state_q == StIdle);
  assign res_valid_o = (state_q == StFinish);
  assign res_data_o  = res_q;

  assign mem_re_o    = (state_q == StScan) && (rd_cnt_q != Depth);
  assign mem_raddr_o = rd_cnt_q[IDX_W-1:0];
  assign mem_we_o    = (state_q == StApply) && (do_ins || do_ref);
  assign mem_waddr_o = hit_q ? hit_idx_q : free_idx_q;
  assign mem_wdata_o = '{ip: ip_q, port: port_q, last_seen: now_q};

  always_comb begin
    res_d = '{status: pat_pkg::StatusOk, present: 1'b0, freed_count: 5'd0};
    case (cmd_q)
      pat_pkg::CmdTouch, pat_pkg::CmdAdd: begin
        if (!hit_q && !free_found_q) begin
          res_d.status = pat_pkg::StatusFull;
        end
      end
      pat_pkg::CmdRemove: begin
        if (!hit_q) begin
          res_d.status = pat_pkg::StatusNotFound;
        end
      end
      pat_pkg::CmdQuery: begin
        res_d.present = hit_q;
      end
      pat_pkg::CmdSweep: begin
        res_d.freed_count = freed_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      valid_q      <= '0;
      now_q        <= '0;
      rd_cnt_q     <= '0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      freed_q      <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            cmd_q        <= in_data_i.cmd;
            ip_q         <= in_data_i.ip_address;
            port_q       <= in_data_i.port_number;
            rd_cnt_q     <= '0;
            cmp_vld_q    <= 1'b0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            freed_q      <= '0;
            if (in_data_i.cmd inside {pat_pkg::CmdTouch, pat_pkg::CmdAdd,
                                      pat_pkg::CmdRemove, pat_pkg::CmdQuery,
                                      pat_pkg::CmdSweep}) begin
              state_q <= StScan;
            end else begin
              state_q <= StApply;
            end
          end
        end
        StScan: begin
          if (rd_cnt_q != Depth) begin
            rd_cnt_q <= rd_cnt_q + CntW'(1);
          end
          cmp_vld_q <= (rd_cnt_q != Depth);
          cmp_idx_q <= rd_cnt_q[IDX_W-1:0];
          if (cmp_vld_q) begin
            if (cmd_q == pat_pkg::CmdSweep) begin
              if (cmp_old) begin
                valid_q[cmp_idx_q] <= 1'b0;
                if (freed_q != pat_pkg::FreedMax) begin
                  freed_q <= freed_q + 5'd1;
                end
              end
            end else begin
              if (cmp_match) begin
                hit_q     <= 1'b1;
                hit_idx_q <= cmp_idx_q;
              end
              if (!cmp_valid && !free_found_q) begin
                free_found_q <= 1'b1;
                free_idx_q   <= cmp_idx_q;
              end
            end
            if (rd_cnt_q == Depth) begin
              state_q <= StApply;
            end
          end
        end
        StApply: begin
          res_q <= res_d;
          case (cmd_q)
            pat_pkg::CmdTick: begin
              now_q <= now_q + 32'd1;
            end
            pat_pkg::CmdTouch, pat_pkg::CmdAdd: begin
              if (do_ins) begin
                valid_q[free_idx_q] <= 1'b1;
              end
            end
            pat_pkg::CmdRemove: begin
              if (hit_q) begin
                valid_q[hit_idx_q] <= 1'b0;
              end
            end
            default: begin
            end
          endcase
          state_q <= StFinish;
        end
        StFinish: begin
          if (res_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

FILE: rtl/peer_address_table_with_aging.sv
`timescale 1ns / 1ps

// Peer address table with aging: TABLE_DEPTH entries of (IPv4 address, UDP port,
// last-seen second) kept in a single-port-write, registered-read RAM, with valid
// bits in flops that reset clears. Every command except tick (and unused codes)
// walks the whole RAM once through its read port, one entry per cycle, then
// applies at most one write. One command is in flight at a time; the result
// register lets the next input beat be taken while the previous result waits.
// inactive_limit (offset 0x0, reset 60) should only be written while the block
// is idle.
module peer_address_table_with_aging #(
  parameter int unsigned TABLE_DEPTH = pat_pkg::TableDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pat_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pat_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  logic [31:0]     limit_q;
  logic            out_valid_q;
  pat_pkg::out_t   out_q;

  logic            res_valid;
  logic            res_ready;
  pat_pkg::out_t   res_data;

  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  pat_pkg::entry_t mem_rdata;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  pat_pkg::entry_t mem_wdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? limit_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= pat_pkg::LimitReset;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      limit_q <= pwdata;
    end
  end

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res_data;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  pat_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IdxW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .inactive_limit_i (limit_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_data_i        (in_data_i),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_data_o       (res_data),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata)
  );

  pat_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import pat_pkg::*;

  localparam logic [2:0] CmdSpareLo = 3'd6;
  localparam logic [2:0] CmdSpareHi = 3'd7;
  localparam logic [2:0] LimitAddr  = 3'h0;

  localparam int unsigned PeerPool     = 20;
  localparam int unsigned PhaseBeats   = 86;
  localparam int unsigned HoldAfter    = 260;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 40;

  class peer_table_checker;
    logic [31:0] age_limit;
    logic [31:0] seconds;
    bit          slot_used [TableDepth];
    logic [31:0] slot_ip   [TableDepth];
    logic [15:0] slot_port [TableDepth];
    logic [31:0] slot_stamp[TableDepth];
    out_t        expected_replies[$];
    int unsigned bad_replies;
    int unsigned replies_checked;
    int unsigned aged_out;
    int unsigned full_replies;
    int unsigned unknown_removes;
    int unsigned query_hits;

    function new();
      age_limit = LimitReset;
      seconds = '0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      bad_replies = 0;
      replies_checked = 0;
      aged_out = 0;
      full_replies = 0;
      unknown_removes = 0;
      query_hits = 0;
    endfunction

    function int find_peer(logic [31:0] ip, logic [15:0] port);
      for (int i = 0; i < TableDepth; i++) begin
        if (slot_used[i] && slot_ip[i] == ip && slot_port[i] == port) return i;
      end
      return -1;
    endfunction

    function logic [1:0] store_peer(logic [31:0] ip, logic [15:0] port);
      for (int i = 0; i < TableDepth; i++) begin
        if (!slot_used[i]) begin
          slot_used[i] = 1'b1;
          slot_ip[i] = ip;
          slot_port[i] = port;
          slot_stamp[i] = seconds;
          return StatusOk;
        end
      end
      full_replies++;
      return StatusFull;
    endfunction

    function void note_command(in_t c);
      out_t r;
      int   hit;
      r = '0;
      r.status = StatusOk;
      hit = find_peer(c.ip_address, c.port_number);
      case (c.cmd)
        CmdTick: seconds = seconds + 32'd1;
        CmdTouch: begin
          if (hit >= 0) slot_stamp[hit] = seconds;
          else r.status = store_peer(c.ip_address, c.port_number);
        end
        CmdAdd: begin
          if (hit < 0) r.status = store_peer(c.ip_address, c.port_number);
        end
        CmdRemove: begin
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
          end else begin
            r.status = StatusNotFound;
            unknown_removes++;
          end
        end
        CmdQuery: begin
          r.present = (hit >= 0);
          if (hit >= 0) query_hits++;
        end
        CmdSweep: begin
          for (int i = 0; i < TableDepth; i++) begin
            if (slot_used[i] && (seconds - slot_stamp[i]) > age_limit) begin
              slot_used[i] = 1'b0;
              aged_out++;
              if (r.freed_count < FreedMax) r.freed_count = r.freed_count + 5'd1;
            end
          end
        end
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(out_t got);
      out_t want;
      replies_checked++;
      if (expected_replies.size() == 0) begin
        bad_replies++;
        if (bad_replies <= 10)
          $display("[%0t] reply beat with nothing outstanding: %h", $time, got);
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status || got.present !== want.present ||
          got.freed_count !== want.freed_count) begin
        bad_replies++;
        if (bad_replies <= 10)
          $display("[%0t] reply %0d: exp status %0d present %0b freed %0d, got %0d %0b %0d",
                   $time, replies_checked, want.status, want.present, want.freed_count,
                   got.status, got.present, got.freed_count);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  peer_table_checker table_mirror;
  logic [31:0]       peer_ip  [PeerPool];
  logic [15:0]       peer_port[PeerPool];
  int unsigned       gap_cap = 7;
  int unsigned       beats_sent = 0;
  int unsigned       settings_used = 0;

  peer_address_table_with_aging u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic send_command(in_t c);
    int unsigned gap;
    gap = $urandom_range(0, gap_cap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i <= c;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    table_mirror.note_command(c);
    beats_sent++;
  endtask

  task automatic wait_idle(int unsigned settle);
    in_valid_i <= 1'b0;
    while (table_mirror.expected_replies.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LimitAddr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    table_mirror.age_limit = value;
    settings_used++;
  endtask

  // mostly pool peers so lookups hit; a few fully random beats as noise
  function automatic in_t random_command();
    in_t         c;
    int unsigned roll;
    int unsigned p;
    roll = $urandom_range(0, 99);
    p = $urandom_range(0, PeerPool - 1);
    c.ip_address = peer_ip[p];
    c.port_number = peer_port[p];
    if (roll < 24) c.cmd = CmdTick;
    else if (roll < 44) c.cmd = CmdTouch;
    else if (roll < 58) c.cmd = CmdAdd;
    else if (roll < 70) c.cmd = CmdRemove;
    else if (roll < 84) c.cmd = CmdQuery;
    else if (roll < 93) c.cmd = CmdSweep;
    else begin
      c.cmd = 3'($urandom_range(0, 7));
      c.ip_address = $urandom;
      c.port_number = 16'($urandom);
    end
    if (c.cmd == CmdTick || c.cmd == CmdSweep) begin
      c.ip_address = $urandom;
      c.port_number = 16'($urandom);
    end
    return c;
  endfunction

  initial begin
    logic [31:0] phase_limits[7];
    table_mirror = new();
    foreach (peer_ip[p]) begin
      peer_ip[p] = $urandom;
      peer_port[p] = 16'($urandom);
    end
    peer_ip[0] = '0;
    peer_port[0] = '0;
    peer_ip[1] = '1;
    peer_port[1] = '1;
    peer_ip[3] = peer_ip[2];
    peer_port[3] = peer_port[2] ^ 16'h0001;
    peer_ip[5] = peer_ip[4] ^ 32'h8000_0000;
    peer_port[5] = peer_port[4];
    phase_limits = '{32'd0, 32'hFFFF_FFFF, 32'd3, 32'd1, 32'd10,
                     32'($urandom_range(2, 20)), $urandom};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command('{CmdQuery, 32'h0000_0000, 16'h0000});
    send_command('{CmdRemove, 32'hFFFF_FFFF, 16'hFFFF});
    send_command('{CmdAdd, 32'h0000_0000, 16'h0000});
    send_command('{CmdAdd, 32'hFFFF_FFFF, 16'hFFFF});
    send_command('{CmdAdd, 32'h0000_0000, 16'h0000});
    send_command('{CmdTouch, 32'hFFFF_FFFF, 16'hFFFF});
    send_command('{CmdQuery, 32'h0000_0000, 16'h0000});
    send_command('{CmdQuery, 32'h0000_0000, 16'hFFFF});
    send_command('{CmdSpareLo, 32'h0000_0000, 16'h0000});
    send_command('{CmdSpareHi, 32'hFFFF_FFFF, 16'hFFFF});
    for (int i = 0; i < 14; i++)
      send_command('{CmdAdd, 32'h0A00_0000 | 32'(i), 16'h1000 | 16'(i)});
    send_command('{CmdAdd, 32'h0B00_0001, 16'h2000});
    send_command('{CmdTouch, 32'h0B00_0002, 16'h2001});
    send_command('{CmdTick, 32'h0000_0000, 16'h0000});
    send_command('{CmdSweep, 32'h0000_0000, 16'h0000});
    wait_idle(4);

    foreach (phase_limits[k]) begin
      write_limit(phase_limits[k]);
      gap_cap = (k % 2 == 1) ? 0 : 7;
      for (int n = 0; n < PhaseBeats; n++) begin
        if (k == 2 && n == PhaseBeats / 2) wait_idle(4);
        send_command(random_command());
      end
      wait_idle(4);
    end
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d commands under %0d age limits plus the reset value; %0d replies checked",
             beats_sent, settings_used, table_mirror.replies_checked);
    $display("Sweeps aged out %0d peers; %0d table-full, %0d unknown removes, %0d query hits",
             table_mirror.aged_out, table_mirror.full_replies,
             table_mirror.unknown_removes, table_mirror.query_hits);
    if (table_mirror.bad_replies == 0 && table_mirror.expected_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side: random stalls, no-stall stretches, one long hold-off
  initial begin
    int unsigned stall_left;
    bit          held;
    stall_left = 0;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        table_mirror.check_reply(out_data_o);
        if (!held && table_mirror.replies_checked == HoldAfter) begin
          stall_left = HoldCycles;
          held = 1'b1;
        end else if (((table_mirror.replies_checked / 40) % 3) == 1) begin
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 7);
        end
        if (stall_left != 0) out_ready_i <= 1'b0;
      end else if (!out_ready_i) begin
        if (stall_left != 0) stall_left--;
        if (stall_left == 0) out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #(2_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
